[rtl/mlp_troubled_cell_indicator_assert.svh]
// Assertion macros for the troubled cell indicator.
`ifndef MLP_TROUBLED_CELL_INDICATOR_ASSERT_SVH
`define MLP_TROUBLED_CELL_INDICATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define MTCI_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mtci assertion failed");
`define MTCI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mtci assertion failed");
`else
`define MTCI_ASSERT_IMPL(label, ante, cons)
`define MTCI_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/mtci_pkg.sv]
// Shared types and constants for the troubled cell indicator.
`timescale 1ns / 1ps
`default_nettype none
package mtci_pkg;
	localparam int ID_W        = 20;
	localparam int VAL_W       = 32;
	localparam int VOL_W       = 31;
	localparam int MUL_W       = 11;
	localparam int PROD_W      = VAL_W + MUL_W;
	localparam int THRESH_SHIFT = 20;
	localparam int SCALED_W    = PROD_W - THRESH_SHIFT;
	localparam logic [MUL_W-1:0] THRESH_MUL = 11'd1049;

	localparam int MID_DEPTH = 4;
	localparam int MID_PTR_W = 2;
	localparam int MID_CNT_W = 3;
	localparam int OUT_DEPTH = 2;
	localparam int OUT_PTR_W = 1;
	localparam int OUT_CNT_W = 2;

	typedef enum logic [1:0] {
		CLASS_NORMAL  = 2'd0,
		CLASS_SMOOTH  = 2'd1,
		CLASS_TROUBLE = 2'd2
	} mtci_class_t;

	typedef struct packed {
		logic [ID_W-1:0] cell_id;
		logic            last_vertex;
		logic            hit;
		logic            smooth;
	} mtci_vtx_t;

	typedef struct packed {
		logic [ID_W-1:0] cell_id;
		mtci_class_t     cell_class;
	} mtci_res_t;
endpackage
`default_nettype wire

[rtl/mlp_troubled_cell_indicator.sv]
// Top level of the troubled cell indicator.
//
// channel  | handshake              | payload
// ---------+------------------------+-----------------------------------------------
// vertex   | push / full            | cell_id, values, bounds, volume, last_vertex
// result   | pop / empty            | cell_tag, cell_class
//
// One vertex per cycle sustained while full is low; a vertex passes the front
// stage registers s1 and s2 before it enters the mid queue. A last vertex shows
// its result right after the edge that takes it from the mid queue.
// Reset clears the flags, the pipeline valids and both queues; no clearing pass.
// full rises only when the four-entry mid queue is full and both front stages are held.
`timescale 1ns / 1ps
`default_nettype none
`include "mlp_troubled_cell_indicator_assert.svh"
module mlp_troubled_cell_indicator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [mtci_pkg::ID_W-1:0]     cell_id,
	input  logic signed [mtci_pkg::VAL_W-1:0] vertex_value,
	input  logic signed [mtci_pkg::VAL_W-1:0] projected_value,
	input  logic signed [mtci_pkg::VAL_W-1:0] mean_value,
	input  logic signed [mtci_pkg::VAL_W-1:0] bound_low,
	input  logic signed [mtci_pkg::VAL_W-1:0] bound_high,
	input  logic [mtci_pkg::VOL_W-1:0]    cell_volume,
	input  logic                          last_vertex,
	output logic                          empty,
	input  logic                          pop,
	output logic [mtci_pkg::ID_W-1:0]     cell_tag,
	output logic [1:0]                    cell_class
);
	import mtci_pkg::*;

	logic      front_valid;
	mtci_vtx_t front_vtx;
	logic      mid_full;
	logic      mid_empty;
	logic      mid_pop;
	mtci_vtx_t mid_vtx;
	logic      mid_push;

	assign mid_push = front_valid && !mid_full;

	mtci_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.cell_id         (cell_id),
		.vertex_value    (vertex_value),
		.projected_value (projected_value),
		.mean_value      (mean_value),
		.bound_low       (bound_low),
		.bound_high      (bound_high),
		.cell_volume     (cell_volume),
		.last_vertex     (last_vertex),
		.vtx_valid       (front_valid),
		.vtx             (front_vtx),
		.vtx_full        (mid_full)
	);

	mtci_fifo u_mid (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.din    (front_vtx),
		.full   (mid_full),
		.pop    (mid_pop),
		.dout   (mid_vtx),
		.empty  (mid_empty)
	);

	mtci_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.vtx_empty  (mid_empty),
		.vtx        (mid_vtx),
		.vtx_pop    (mid_pop),
		.empty      (empty),
		.pop        (pop),
		.cell_tag   (cell_tag),
		.cell_class (cell_class)
	);

	`MTCI_ASSERT_IMPL(a_mid_pop_nonempty, mid_pop, !mid_empty)
	`MTCI_ASSERT_NEXT(a_last_gives_result, mid_pop && mid_vtx.last_vertex, !empty)
	`MTCI_ASSERT_NEXT(a_full_holds_front, full && !mid_pop, mid_full || !full)
endmodule
`default_nettype wire

[rtl/mtci_front.sv]
// Front end: classifies each vertex in two pipeline stages.
`timescale 1ns / 1ps
`default_nettype none
module mtci_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [mtci_pkg::ID_W-1:0]     cell_id,
	input  logic signed [mtci_pkg::VAL_W-1:0] vertex_value,
	input  logic signed [mtci_pkg::VAL_W-1:0] projected_value,
	input  logic signed [mtci_pkg::VAL_W-1:0] mean_value,
	input  logic signed [mtci_pkg::VAL_W-1:0] bound_low,
	input  logic signed [mtci_pkg::VAL_W-1:0] bound_high,
	input  logic [mtci_pkg::VOL_W-1:0]    cell_volume,
	input  logic                          last_vertex,
	output logic                          vtx_valid,
	output mtci_pkg::mtci_vtx_t           vtx,
	input  logic                          vtx_full
);
	import mtci_pkg::*;

	logic                    valid_s1;
	logic [ID_W-1:0]         id_s1;
	logic                    last_s1;
	logic                    oob_s1;
	logic                    smooth_s1;
	logic [VAL_W:0]          abs_diff_s1;
	logic [SCALED_W-1:0]     scaled_s1;
	logic [VOL_W-1:0]        vol_s1;
	logic                    valid_s2;
	mtci_vtx_t               vtx_s2;

	logic                    take_s1;
	logic                    take_s2;
	logic [VAL_W-1:0]        abs_mean;
	logic signed [VAL_W:0]   diff;
	logic [VAL_W:0]          abs_diff;
	logic [PROD_W-1:0]       prod;
	logic                    oob;
	logic                    smooth;
	logic [VOL_W-1:0]        thresh;
	logic                    near_const;

	assign take_s2 = !valid_s2 || !vtx_full;
	assign take_s1 = !valid_s1 || take_s2;
	assign full    = !take_s1;

	always_comb begin
		abs_mean = mean_value[VAL_W-1] ? VAL_W'(-mean_value) : VAL_W'(mean_value);
		diff     = {vertex_value[VAL_W-1], vertex_value} - {mean_value[VAL_W-1], mean_value};
		abs_diff = diff[VAL_W] ? (VAL_W+1)'(-diff) : (VAL_W+1)'(diff);
		prod     = {{MUL_W{1'b0}}, abs_mean} * {{VAL_W{1'b0}}, THRESH_MUL};
		oob      = (projected_value < bound_low) || (projected_value > bound_high);
		smooth   = ((projected_value > mean_value) && (vertex_value < projected_value) &&
			(vertex_value > bound_low)) ||
			((projected_value < mean_value) && (vertex_value > projected_value) &&
			(vertex_value < bound_high));
	end

	always_comb begin
		thresh     = (VOL_W'(scaled_s1) > vol_s1) ? VOL_W'(scaled_s1) : vol_s1;
		near_const = abs_diff_s1 <= (VAL_W+1)'(thresh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_s1) valid_s1 <= push;
			if (take_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && push) begin
			id_s1       <= cell_id;
			last_s1     <= last_vertex;
			oob_s1      <= oob;
			smooth_s1   <= smooth;
			abs_diff_s1 <= abs_diff;
			scaled_s1   <= prod[PROD_W-1:THRESH_SHIFT];
			vol_s1      <= cell_volume;
		end
		if (take_s2 && valid_s1) begin
			vtx_s2.cell_id     <= id_s1;
			vtx_s2.last_vertex <= last_s1;
			vtx_s2.hit         <= oob_s1 && !near_const;
			vtx_s2.smooth      <= smooth_s1;
		end
	end

	assign vtx_valid = valid_s2;
	assign vtx       = vtx_s2;
endmodule
`default_nettype wire

[rtl/mtci_fifo.sv]
// Short queue of classified vertices between front and back.
`timescale 1ns / 1ps
`default_nettype none
module mtci_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mtci_pkg::mtci_vtx_t din,
	output logic                full,
	input  logic                pop,
	output mtci_pkg::mtci_vtx_t dout,
	output logic                empty
);
	import mtci_pkg::*;

	mtci_vtx_t              mem_q [MID_DEPTH];
	logic [MID_PTR_W-1:0]   wr_ptr_q;
	logic [MID_PTR_W-1:0]   rd_ptr_q;
	logic [MID_CNT_W-1:0]   cnt_q;
	logic                   do_push;
	logic                   do_pop;

	assign full    = cnt_q == MID_CNT_W'(MID_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= din;
	end
endmodule
`default_nettype wire

[rtl/mtci_back.sv]
// Back end: accumulates cell flags and queues the cell class results.
`timescale 1ns / 1ps
`default_nettype none
module mtci_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      vtx_empty,
	input  mtci_pkg::mtci_vtx_t       vtx,
	output logic                      vtx_pop,
	output logic                      empty,
	input  logic                      pop,
	output logic [mtci_pkg::ID_W-1:0] cell_tag,
	output logic [1:0]                cell_class
);
	import mtci_pkg::*;

	logic                 smooth_seen_q;
	logic                 trouble_seen_q;
	mtci_res_t            res_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q;
	logic [OUT_PTR_W-1:0] rd_ptr_q;
	logic [OUT_CNT_W-1:0] cnt_q;

	logic                 res_full;
	logic                 res_push;
	logic                 res_pop;
	logic                 smooth_next;
	logic                 trouble_next;
	mtci_res_t            res;

	assign res_full = cnt_q == OUT_CNT_W'(OUT_DEPTH);
	assign empty    = cnt_q == '0;
	assign res_pop  = pop && !empty;
	assign vtx_pop  = !vtx_empty && (!vtx.last_vertex || !res_full);
	assign res_push = vtx_pop && vtx.last_vertex;

	always_comb begin
		smooth_next  = smooth_seen_q || (vtx.hit && vtx.smooth);
		trouble_next = trouble_seen_q || (vtx.hit && !vtx.smooth);
		res.cell_id  = vtx.cell_id;
		priority if (trouble_next) res.cell_class = CLASS_TROUBLE;
		else if (smooth_next)      res.cell_class = CLASS_SMOOTH;
		else                       res.cell_class = CLASS_NORMAL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_seen_q  <= 1'b0;
			trouble_seen_q <= 1'b0;
			wr_ptr_q       <= '0;
			rd_ptr_q       <= '0;
			cnt_q          <= '0;
		end else begin
			if (vtx_pop) begin
				smooth_seen_q  <= smooth_next && !vtx.last_vertex;
				trouble_seen_q <= trouble_next && !vtx.last_vertex;
			end
			if (res_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (res_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (res_push && !res_pop)      cnt_q <= cnt_q + 1'b1;
			else if (res_pop && !res_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) res_q[wr_ptr_q] <= res;
	end

	assign cell_tag   = res_q[rd_ptr_q].cell_id;
	assign cell_class = res_q[rd_ptr_q].cell_class;
endmodule
`default_nettype wire

[dv/mlp_troubled_cell_indicator_test.sv]
// Testbench for the troubled cell indicator: directed and randomized vertex streams checked against a cell classifier.
`timescale 1ns / 1ps
module mlp_troubled_cell_indicator_test;
	import mtci_pkg::*;

	localparam int SCALE_MUL     = 1049;
	localparam int SCALE_SHIFT   = 20;
	localparam int RANDOM_ITEMS  = 550;
	localparam int PRESSURE_AT   = 250;
	localparam int PRESSURE_ITEMS = 40;
	localparam int LONG_HOLD     = 300;
	localparam int TAIL_CYCLES   = 12;
	localparam int IDLE_LIMIT    = 5000;

	typedef struct packed {
		logic [ID_W-1:0]         id;
		logic signed [VAL_W-1:0] val;
		logic signed [VAL_W-1:0] proj;
		logic signed [VAL_W-1:0] mean;
		logic signed [VAL_W-1:0] lo;
		logic signed [VAL_W-1:0] hi;
		logic [VOL_W-1:0]        vol;
		logic                    last;
	} vertex_t;

	typedef struct {
		logic [ID_W-1:0] tag;
		mtci_class_t     cls;
	} verdict_t;

	typedef enum {V_FLAT, V_BOUNDED, V_SMOOTH_PEAK, V_SMOOTH_DIP, V_ROUGH, V_SWAPPED, V_RAW}
		vertex_kind_t;
	typedef enum {DRAIN_ALL, DRAIN_HALF, DRAIN_SPARSE, DRAIN_MOST} drain_mode_t;

	class cell_verdict_board;
		bit smooth_seen;
		bit trouble_seen;
		verdict_t awaited_verdicts[$];
		int mismatches;
		int vertices_seen;
		int class_hits[3];

		function void note_vertex(vertex_t v);
			longint val, proj, mean, lo, hi, vol, scaled, limit, dev_abs, higher, p1;
			bit flat, in_range, smooth;
			verdict_t vd;
			val  = $signed(v.val);
			proj = $signed(v.proj);
			mean = $signed(v.mean);
			lo   = $signed(v.lo);
			hi   = $signed(v.hi);
			vol  = longint'(v.vol);
			scaled = ((mean < 0 ? -mean : mean) * SCALE_MUL) >>> SCALE_SHIFT;
			limit = scaled > vol ? scaled : vol;
			dev_abs = val - mean;
			if (dev_abs < 0)
				dev_abs = -dev_abs;
			flat = dev_abs <= limit;
			in_range = lo <= proj && proj <= hi;
			if (!flat && !in_range) begin
				higher = val - proj;
				p1 = proj - mean;
				smooth = (p1 > 0 && higher < 0 && val > lo) || (p1 < 0 && higher > 0 && val < hi);
				if (smooth)
					smooth_seen = 1;
				else
					trouble_seen = 1;
			end
			vertices_seen++;
			if (v.last) begin
				vd.tag = v.id;
				vd.cls = trouble_seen ? CLASS_TROUBLE : (smooth_seen ? CLASS_SMOOTH : CLASS_NORMAL);
				awaited_verdicts.push_back(vd);
				smooth_seen = 0;
				trouble_seen = 0;
			end
		endfunction

		function void check_result(logic [ID_W-1:0] tag, logic [1:0] cls);
			verdict_t want;
			if (awaited_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result cell_tag %h cell_class %0d", $realtime, tag, cls);
				return;
			end
			want = awaited_verdicts.pop_front();
			if (tag !== want.tag || cls !== want.cls) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: cell_tag exp %h got %h, cell_class exp %0d got %0d",
						$realtime, want.tag, tag, want.cls, cls);
			end else if (cls <= 2) begin
				class_hits[cls]++;
			end
		endfunction

		function int pending();
			return awaited_verdicts.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic push;
	logic pop;
	vertex_t drv;
	logic full;
	logic empty;
	logic [ID_W-1:0] cell_tag;
	logic [1:0] cell_class;

	cell_verdict_board board = new();
	int idle_cycles;
	int full_cycles;
	int burst_left;
	bit long_hold_req;

	mlp_troubled_cell_indicator dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.cell_id(drv.id),
		.vertex_value(drv.val),
		.projected_value(drv.proj),
		.mean_value(drv.mean),
		.bound_low(drv.lo),
		.bound_high(drv.hi),
		.cell_volume(drv.vol),
		.last_vertex(drv.last),
		.empty(empty),
		.pop(pop),
		.cell_tag(cell_tag),
		.cell_class(cell_class)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && ((push && !full) || (pop && !empty)))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (arst_n && push && !full)
			board.note_vertex(drv);
		if (arst_n && push && full)
			full_cycles <= full_cycles + 1;
		if (arst_n && pop && !empty)
			board.check_result(cell_tag, cell_class);
	end

	function automatic longint spread(longint low_v, longint high_v);
		return low_v + longint'($urandom_range(0, int'(high_v - low_v)));
	endfunction

	function automatic vertex_t make_fixed(logic [ID_W-1:0] id, logic [31:0] val,
			logic [31:0] proj, logic [31:0] mean, logic [31:0] lo, logic [31:0] hi,
			logic [30:0] vol, logic last);
		vertex_t v;
		v.id = id;
		v.val = val;
		v.proj = proj;
		v.mean = mean;
		v.lo = lo;
		v.hi = hi;
		v.vol = vol;
		v.last = last;
		return v;
	endfunction

	function automatic vertex_t make_vertex(vertex_kind_t kind, logic [ID_W-1:0] id, logic last);
		longint m, a, b, c, vol, scaled, t, val, proj, lo, hi;
		vertex_t v;
		m = spread(-(64'sd1 << 28), 64'sd1 << 28);
		a = spread(64'sd1 << 19, 64'sd1 << 23);
		b = spread(64'sd1 << 19, 64'sd1 << 23);
		c = spread(2, 64'sd1 << 22);
		vol = $urandom_range(0, 4095);
		scaled = ((m < 0 ? -m : m) * SCALE_MUL) >>> SCALE_SHIFT;
		t = scaled > vol ? scaled : vol;
		lo = m - a;
		hi = m + b;
		proj = spread(lo, hi);
		val = m + spread(-(64'sd1 << 24), 64'sd1 << 24);
		case (kind)
			V_FLAT: begin
				val = m + spread(-t, t);
				proj = m + spread(-(64'sd1 << 24), 64'sd1 << 24);
			end
			V_BOUNDED: ;
			V_SMOOTH_PEAK: begin
				proj = hi + c;
				val = proj - spread(1, c);
			end
			V_SMOOTH_DIP: begin
				proj = lo - c;
				val = proj + spread(1, c);
			end
			V_ROUGH: begin
				case ($urandom_range(0, 2))
					0: begin
						proj = hi + c;
						val = proj + spread(0, 64'sd1 << 22);
					end
					1: begin
						proj = lo - c;
						val = proj - spread(0, 64'sd1 << 22);
					end
					default: begin
						proj = hi + c;
						val = lo - spread(0, 64'sd1 << 22);
					end
				endcase
			end
			V_SWAPPED: begin
				lo = m + b;
				hi = m - a;
				proj = m + spread(-(64'sd1 << 24), 64'sd1 << 24);
			end
			default: ;
		endcase
		v.id = id;
		v.val = val[31:0];
		v.proj = proj[31:0];
		v.mean = m[31:0];
		v.lo = lo[31:0];
		v.hi = hi[31:0];
		v.vol = vol[30:0];
		v.last = last;
		if (kind == V_RAW) begin
			v.val = $urandom;
			v.proj = $urandom;
			v.mean = $urandom;
			v.lo = $urandom;
			v.hi = $urandom;
			v.vol = VOL_W'($urandom >> $urandom_range(1, 31));
		end
		return v;
	endfunction

	function automatic vertex_kind_t pick_kind(int flavor);
		int r;
		r = $urandom_range(0, 99);
		case (flavor)
			0: return r < 50 ? V_FLAT : V_BOUNDED;
			1: begin
				if (r < 35) return V_FLAT;
				if (r < 70) return V_BOUNDED;
				return r < 85 ? V_SMOOTH_PEAK : V_SMOOTH_DIP;
			end
			2: begin
				if (r < 25) return V_FLAT;
				if (r < 50) return V_BOUNDED;
				if (r < 65) return V_SMOOTH_PEAK;
				if (r < 80) return V_SMOOTH_DIP;
				return r < 92 ? V_ROUGH : V_SWAPPED;
			end
			default: begin
				if (r < 60) return V_RAW;
				if (r < 80) return V_ROUGH;
				return V_SMOOTH_PEAK;
			end
		endcase
	endfunction

	task automatic send_vertex(vertex_t v);
		drv <= v;
		push <= 1'b1;
		do @(posedge clk); while (full);
	endtask

	task automatic send_paced(vertex_t v);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				burst_left = $urandom_range(20, 40);
				gap = 0;
			end else begin
				burst_left = $urandom_range(1, 16);
				gap = $urandom_range(0, 8);
			end
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		send_vertex(v);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		drain_mode_t mode;
		int mode_left;
		mode = DRAIN_ALL;
		mode_left = 0;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 0;
				pop <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = drain_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(10, 80);
				end
				mode_left--;
				case (mode)
					DRAIN_ALL: pop <= 1'b1;
					DRAIN_HALF: pop <= 1'($urandom_range(0, 1));
					DRAIN_SPARSE: pop <= ($urandom_range(0, 3) == 0);
					default: pop <= ($urandom_range(0, 7) != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("%0t: no item moved for %0d cycles", $realtime, IDLE_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int sent, n, flavor;
		logic [ID_W-1:0] id;
		vertex_t v;
		bit hold_done;
		sent = 0;
		hold_done = 0;
		burst_left = 0;
		long_hold_req = 0;
		idle_cycles = 0;
		full_cycles = 0;
		arst_n <= 1'b0;
		push <= 1'b0;
		drv <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_paced(make_fixed(20'h00000, 32'h4010_6400, 32'h7FFF_0000, 32'h4000_0000,
			32'h0, 32'h5000_0000, 31'h0, 1'b1));
		send_paced(make_fixed(20'hFFFFF, 32'h4010_6401, 32'h7FFF_0000, 32'h4000_0000,
			32'h0, 32'h5000_0000, 31'h0, 1'b1));
		send_paced(make_fixed(20'h00001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
			32'hFFFF_FFFF, 32'h1, 31'h7FFF_FFFF, 1'b1));
		send_paced(make_fixed(20'h00002, 32'h8000_0000, 32'h8000_0000, 32'h0,
			32'h8000_0001, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1));
		send_paced(make_fixed(20'h00003, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 32'h7FFF_FFFE, 31'h0, 1'b1));
		send_paced(make_fixed(20'h00004, -32'sh2_0000, -32'sh3_0000, 32'h0,
			-32'sh1_0000, 32'h1_0000, 31'h100, 1'b1));
		send_paced(make_fixed(20'h00005, 32'h8000, 32'h0, 32'h0,
			32'h1_0000, -32'sh1_0000, 31'h100, 1'b1));
		send_paced(make_fixed(20'h00006, -32'sh2_0000, -32'sh3_0000, 32'h0,
			32'h5_0000, 32'h1_0000, 31'h100, 1'b1));
		send_paced(make_fixed(20'h00007, -32'sh2_0000, -32'sh3_0000, 32'h0,
			-32'sh1_0000, 32'h1_0000, 31'h100, 1'b0));
		send_paced(make_fixed(20'h00007, 32'h5_0000, 32'h2_0000, 32'h0,
			-32'sh1_0000, 32'h1_0000, 31'h100, 1'b0));
		send_paced(make_fixed(20'h00007, 32'h5_0000, 32'h0, 32'h0,
			-32'sh1_0000, 32'h1_0000, 31'h100, 1'b1));
		send_paced(make_fixed(20'h00008, 32'h2_0000, 32'h3_0000, 32'h0,
			-32'sh1_0000, 32'h1_0000, 31'h100, 1'b0));
		send_paced(make_fixed(20'h00008, 32'h80, 32'h3_0000, 32'h0,
			-32'sh1_0000, 32'h1_0000, 31'h100, 1'b1));
		send_paced(make_fixed(20'h00009, 32'h5_0000, 32'h2_0000, 32'h0,
			-32'sh1_0000, 32'h1_0000, 31'h100, 1'b0));
		send_paced(make_fixed(20'h0000A, 32'h5_0000, 32'h0, 32'h0,
			-32'sh1_0000, 32'h1_0000, 31'h100, 1'b1));
		send_paced(make_fixed(20'h0000B, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 31'h0, 1'b1));
		send_paced(make_fixed(20'h0000C, 32'h10_0000, -32'sh5, 32'h0,
			-32'sh5, 32'h5, 31'h0, 1'b0));
		send_paced(make_fixed(20'h0000C, 32'h10_0000, 32'h5, 32'h0,
			-32'sh5, 32'h5, 31'h0, 1'b1));
		send_paced(make_fixed(20'h0000D, -32'sh1_0000, 32'h1_0001, 32'h0,
			-32'sh1_0000, 32'h1_0000, 31'h0, 1'b1));
		wait_drained();

		while (sent < RANDOM_ITEMS) begin
			n = $urandom_range(1, 6);
			id = ID_W'($urandom);
			flavor = $urandom_range(0, 3);
			for (int k = 0; k < n; k++) begin
				v = make_vertex(pick_kind(flavor), id, k == n - 1);
				if ($urandom_range(0, 29) == 0)
					v.id = ID_W'($urandom);
				if ($urandom_range(0, 24) == 0)
					v.last = 1'b0;
				send_paced(v);
				sent++;
			end
			if (!hold_done && sent >= PRESSURE_AT) begin
				hold_done = 1;
				wait_drained();
				long_hold_req = 1;
				for (int k = 0; k < PRESSURE_ITEMS; k++)
					send_vertex(make_vertex(pick_kind(2), ID_W'($urandom), 1'b1));
				sent += PRESSURE_ITEMS;
				wait_drained();
				burst_left = 0;
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Run covered %0d vertices and %0d cell results (%0d normal, %0d smooth, %0d troubled)",
			board.vertices_seen, board.class_hits[0] + board.class_hits[1] + board.class_hits[2],
			board.class_hits[0], board.class_hits[1], board.class_hits[2]);
		$display("Input held off by full for %0d cycles; %0d mismatches",
			full_cycles, board.mismatches);
		if (board.pending() != 0)
			$display("%0d cell results never arrived", board.pending());
		if (board.mismatches == 0 && board.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
